// ----- rtl/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int ID_W      = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int TIME_W    = 16;
  localparam int BURST_W   = 16;
  localparam int QUANT_W   = 8;

  localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(2);
  localparam logic [QUANT_W-1:0] SLICE_MAX   = '1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BUSY = 2'd2
  } status_e;

  typedef enum logic {
    ACT_ARRIVE = 1'b0,
    ACT_TICK   = 1'b1
  } action_e;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  typedef struct packed {
    logic arrive;
    logic select;
    logic run;
  } cmd_t;

endpackage

// ----- rtl/rrts_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencer: arrive requests finish in the accept cycle, tick requests take
// a select step and a run step.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          action_i,
  output logic          busy,
  output rrts_pkg::cmd_t cmd_o
);
  import rrts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start && (action_i == ACT_TICK)) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.arrive = start && (action_i == ACT_ARRIVE);
        cmd_o.select = start && (action_i == ACT_TICK);
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        busy      = 1'b1;
      end
      default: begin
        cmd_o = '0;
        busy  = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/rrts_dp.sv -----
// ----------------------------------------------------------------------------
// rrts_dp
// Ready FIFO, per-task tables, current task, tick counter and result register.
// ----------------------------------------------------------------------------
module rrts_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrts_pkg::cmd_t                cmd_i,
  input  logic [rrts_pkg::ID_W-1:0]     task_id_i,
  input  logic [rrts_pkg::BURST_W-1:0]  burst_len_i,
  input  logic                          cfg_we_i,
  input  logic [rrts_pkg::QUANT_W-1:0]  cfg_wdata_i,
  output logic                          valid_o,
  output logic [1:0]                    status_o,
  output logic                          running_valid_o,
  output logic [rrts_pkg::ID_W-1:0]     running_task_o,
  output logic                          done_valid_o,
  output logic [rrts_pkg::ID_W-1:0]     done_task_o,
  output logic [rrts_pkg::TIME_W-1:0]   turnaround_o,
  output logic [rrts_pkg::TIME_W-1:0]   waiting_o,
  output logic [rrts_pkg::TIME_W-1:0]   time_now_o
);
  import rrts_pkg::*;

  // tables, undefined until written
  logic [ID_W-1:0]    fifo_q  [MAX_TASKS];
  logic [TIME_W-1:0]  arr_q   [MAX_TASKS];
  logic [BURST_W-1:0] burst_q [MAX_TASKS];
  logic [BURST_W-1:0] ticks_q [MAX_TASKS];

  // registered read data
  logic [ID_W-1:0]      head_rd_q;
  logic [TIME_W-1:0]    arr_rd_q;
  logic [BURST_W-1:0]   burst_rd_q;
  logic [BURST_W-1:0]   ticks_rd_q;

  logic [MAX_TASKS-1:0] active_q, active_d;
  logic [QUANT_W-1:0]   quant_q;
  logic [TIME_W-1:0]    tick_q, tick_d;
  logic [QUANT_W-1:0]   slice_q, slice_d;
  logic [ID_W-1:0]      cur_q, cur_d;
  logic                 cur_vld_q, cur_vld_d;
  logic [ID_W-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  logic                 fifo_we;
  logic [ID_W-1:0]      fifo_wdata;
  logic                 tab_we;
  logic                 ticks_we;
  logic [ID_W-1:0]      ticks_addr;
  logic [BURST_W-1:0]   ticks_wdata;

  logic                 preempt, take;
  logic [ID_W-1:0]      pop_id;
  logic [BURST_W-1:0]   ticks_inc, cur_burst;
  logic                 fin;
  logic [TIME_W-1:0]    tat, wt;
  status_e              arr_status;

  logic                 res_vld_d, res_vld_q;
  logic [1:0]           res_status_d, res_status_q;
  logic                 res_run_v_d, res_run_v_q;
  logic [ID_W-1:0]      res_run_t_d, res_run_t_q;
  logic                 res_done_v_d, res_done_v_q;
  logic [ID_W-1:0]      res_done_t_d, res_done_t_q;
  logic [TIME_W-1:0]    res_tat_d, res_tat_q;
  logic [TIME_W-1:0]    res_wt_d, res_wt_q;
  logic [TIME_W-1:0]    res_now_d, res_now_q;

  always_comb begin
    if (cnt_q[CNT_W-1]) begin
      arr_status = ST_FULL;
    end else if (active_q[task_id_i]) begin
      arr_status = ST_BUSY;
    end else begin
      arr_status = ST_OK;
    end
  end

  // select step
  assign preempt = cur_vld_q && (slice_q >= quant_q);
  assign take    = (!cur_vld_q || preempt) && ((cnt_q != '0) || preempt);
  // requeued task comes straight back when the queue was empty
  assign pop_id  = (preempt && (cnt_q == '0)) ? cur_q : head_rd_q;

  // run step
  assign cur_burst = burst_rd_q;
  assign ticks_inc = ticks_rd_q + BURST_W'(1);
  assign fin       = ticks_inc >= cur_burst;
  assign tat       = tick_q + TIME_W'(1) - arr_rd_q;
  assign wt        = tat - TIME_W'(cur_burst);

  always_comb begin
    active_d    = active_q;
    tick_d      = tick_q;
    slice_d     = slice_q;
    cur_d       = cur_q;
    cur_vld_d   = cur_vld_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    fifo_we     = 1'b0;
    fifo_wdata  = task_id_i;
    tab_we      = 1'b0;
    ticks_we    = 1'b0;
    ticks_addr  = task_id_i;
    ticks_wdata = '0;

    res_vld_d    = 1'b0;
    res_status_d = ST_OK;
    res_run_v_d  = cur_vld_q;
    res_run_t_d  = cur_vld_q ? cur_q : '0;
    res_done_v_d = 1'b0;
    res_done_t_d = '0;
    res_tat_d    = '0;
    res_wt_d     = '0;
    res_now_d    = tick_q;

    priority if (cmd_i.arrive) begin
      res_vld_d    = 1'b1;
      res_status_d = arr_status;
      if (arr_status == ST_OK) begin
        tab_we              = 1'b1;
        ticks_we            = 1'b1;
        active_d[task_id_i] = 1'b1;
        fifo_we             = 1'b1;
        tail_d              = tail_q + ID_W'(1);
        cnt_d               = cnt_q + CNT_W'(1);
      end
    end else if (cmd_i.select) begin
      if (preempt) begin
        fifo_we    = 1'b1;
        fifo_wdata = cur_q;
        tail_d     = tail_q + ID_W'(1);
      end
      if (take) begin
        cur_d     = pop_id;
        cur_vld_d = 1'b1;
        slice_d   = '0;
        head_d    = head_q + ID_W'(1);
      end
      cnt_d = cnt_q + CNT_W'(preempt) - CNT_W'(take);
    end else if (cmd_i.run) begin
      res_vld_d = 1'b1;
      tick_d    = tick_q + TIME_W'(1);
      if (cur_vld_q) begin
        ticks_we    = 1'b1;
        ticks_addr  = cur_q;
        ticks_wdata = ticks_inc;
        if (slice_q != SLICE_MAX) begin
          slice_d = slice_q + QUANT_W'(1);
        end
        if (fin) begin
          res_done_v_d    = 1'b1;
          res_done_t_d    = cur_q;
          res_tat_d       = tat;
          res_wt_d        = wt;
          active_d[cur_q] = 1'b0;
          cur_vld_d       = 1'b0;
          slice_d         = '0;
        end
      end
    end else begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      quant_q   <= QUANT_RESET;
      tick_q    <= '0;
      slice_q   <= '0;
      cur_q     <= '0;
      cur_vld_q <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      active_q  <= active_d;
      tick_q    <= tick_d;
      slice_q   <= slice_d;
      cur_q     <= cur_d;
      cur_vld_q <= cur_vld_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
      res_vld_q <= res_vld_d;
      if (cfg_we_i) begin
        quant_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_q[tail_q] <= fifo_wdata;
    end
    // head entry, with write-through when the new head is written now
    if (fifo_we && (tail_q == head_d)) begin
      head_rd_q <= fifo_wdata;
    end else begin
      head_rd_q <= fifo_q[head_d];
    end
    if (tab_we) begin
      arr_q[task_id_i]   <= tick_q;
      burst_q[task_id_i] <= burst_len_i;
    end
    if (ticks_we) begin
      ticks_q[ticks_addr] <= ticks_wdata;
    end
    // table entries of the selected task for the run step
    if (cmd_i.select) begin
      arr_rd_q   <= arr_q[cur_d];
      burst_rd_q <= burst_q[cur_d];
      ticks_rd_q <= ticks_q[cur_d];
    end
    if (res_vld_d) begin
      res_status_q <= res_status_d;
      res_run_v_q  <= res_run_v_d;
      res_run_t_q  <= res_run_t_d;
      res_done_v_q <= res_done_v_d;
      res_done_t_q <= res_done_t_d;
      res_tat_q    <= res_tat_d;
      res_wt_q     <= res_wt_d;
      res_now_q    <= res_now_d;
    end
  end

  assign valid_o         = res_vld_q;
  assign status_o        = res_status_q;
  assign running_valid_o = res_run_v_q;
  assign running_task_o  = res_run_t_q;
  assign done_valid_o    = res_done_v_q;
  assign done_task_o     = res_done_t_q;
  assign turnaround_o    = res_tat_q;
  assign waiting_o       = res_wt_q;
  assign time_now_o      = res_now_q;

endmodule

// ----- rtl/round_robin_time_slice_scheduler.sv -----
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler
// An arrive request gives its result in the cycle after acceptance and busy stays
// low, so one arrive per cycle while no tick is in progress. A tick request takes a
// select step, then a run step on the task tables; busy is high for one cycle and
// its result appears in the cycle after the run step. Results are strobed by valid_o.
// Reset clears queue pointers, active marks, time and current task; the
// quantum returns to 2. Task tables hold no value until written.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic [rrts_pkg::ID_W-1:0]     task_id_i,
  input  logic [rrts_pkg::BURST_W-1:0]  burst_len_i,
  input  logic                          cfg_we_i,
  input  logic [rrts_pkg::QUANT_W-1:0]  cfg_wdata_i,
  output logic                          valid_o,
  output logic [1:0]                    status_o,
  output logic                          running_valid_o,
  output logic [rrts_pkg::ID_W-1:0]     running_task_o,
  output logic                          done_valid_o,
  output logic [rrts_pkg::ID_W-1:0]     done_task_o,
  output logic [rrts_pkg::TIME_W-1:0]   turnaround_o,
  output logic [rrts_pkg::TIME_W-1:0]   waiting_o,
  output logic [rrts_pkg::TIME_W-1:0]   time_now_o
);
  import rrts_pkg::*;

  cmd_t cmd;

  rrts_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  rrts_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .task_id_i       (task_id_i),
    .burst_len_i     (burst_len_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .valid_o         (valid_o),
    .status_o        (status_o),
    .running_valid_o (running_valid_o),
    .running_task_o  (running_task_o),
    .done_valid_o    (done_valid_o),
    .done_task_o     (done_task_o),
    .turnaround_o    (turnaround_o),
    .waiting_o       (waiting_o),
    .time_now_o      (time_now_o)
  );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the round-robin time-slice scheduler. A directed
// table covers reset, busy ids, a full ready queue and zero and maximum burst
// lengths. Random phases then run with quantum settings of 1, 0, 255, a random
// value and 3, and a final random phase runs without gaps. Every request goes
// through a local schedule model, and each strobed result is compared field
// by field.
// ----------------------------------------------------------------------------
module tb;
  import rrts_pkg::*;

  localparam int STALL_LIMIT = 500;

  typedef struct packed {
    status_e             status;
    logic                run_v;
    logic [ID_W-1:0]     run_t;
    logic                done_v;
    logic [ID_W-1:0]     done_t;
    logic [TIME_W-1:0]   tat;
    logic [TIME_W-1:0]   wt;
    logic [TIME_W-1:0]   now;
  } sched_result_t;

  typedef struct {
    action_e             act;
    logic [ID_W-1:0]     id;
    logic [BURST_W-1:0]  burst;
    bit                  checked;
    sched_result_t       want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 action_i;
  logic [ID_W-1:0]      task_id_i;
  logic [BURST_W-1:0]   burst_len_i;
  logic                 cfg_we_i;
  logic [QUANT_W-1:0]   cfg_wdata_i;
  logic                 valid_o;
  logic [1:0]           status_o;
  logic                 running_valid_o;
  logic [ID_W-1:0]      running_task_o;
  logic                 done_valid_o;
  logic [ID_W-1:0]      done_task_o;
  logic [TIME_W-1:0]    turnaround_o;
  logic [TIME_W-1:0]    waiting_o;
  logic [TIME_W-1:0]    time_now_o;

  // schedule model state
  logic [QUANT_W-1:0]   quantum_cfg = QUANT_RESET;
  logic [TIME_W-1:0]    sim_time    = '0;
  logic [QUANT_W-1:0]   slice_used  = '0;
  logic [ID_W-1:0]      cur_id      = '0;
  bit                   cur_busy    = 1'b0;
  logic [ID_W-1:0]      ready_q [MAX_TASKS];
  logic [ID_W-1:0]      rq_head     = '0;
  logic [ID_W-1:0]      rq_tail     = '0;
  int                   rq_count    = 0;
  logic [TIME_W-1:0]    arrived_at [MAX_TASKS];
  logic [BURST_W-1:0]   burst_need [MAX_TASKS];
  logic [BURST_W-1:0]   ticks_done [MAX_TASKS];
  bit                   is_active [MAX_TASKS];

  sched_result_t        pending_results [$];
  sched_result_t        typed_result;
  bit                   typed_valid;
  sched_result_t        got_result;
  sched_result_t        model_result;
  bit                   gaps_on;
  int                   mismatches  = 0;
  int                   idle_cycles = 0;
  stim_row_t            dir_rows [24];

  round_robin_time_slice_scheduler DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .task_id_i       (task_id_i),
    .burst_len_i     (burst_len_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .valid_o         (valid_o),
    .status_o        (status_o),
    .running_valid_o (running_valid_o),
    .running_task_o  (running_task_o),
    .done_valid_o    (done_valid_o),
    .done_task_o     (done_task_o),
    .turnaround_o    (turnaround_o),
    .waiting_o       (waiting_o),
    .time_now_o      (time_now_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic sched_result_t next_sched_result(action_e act, logic [ID_W-1:0] id,
                                                      logic [BURST_W-1:0] burst);
    sched_result_t r;
    logic [ID_W-1:0] t;
    r = '0;
    r.status = ST_OK;
    r.now = sim_time;
    if (act == ACT_ARRIVE) begin
      if (rq_count >= MAX_TASKS) begin
        r.status = ST_FULL;
      end else if (is_active[id]) begin
        r.status = ST_BUSY;
      end else begin
        arrived_at[id] = sim_time;
        burst_need[id] = burst;
        ticks_done[id] = '0;
        is_active[id] = 1'b1;
        ready_q[rq_tail] = id;
        rq_tail++;
        rq_count++;
      end
      if (cur_busy) begin
        r.run_v = 1'b1;
        r.run_t = cur_id;
      end
    end else begin
      // preempted task goes behind anything that arrived meanwhile
      if (cur_busy && slice_used >= quantum_cfg) begin
        if (rq_count < MAX_TASKS) begin
          ready_q[rq_tail] = cur_id;
          rq_tail++;
          rq_count++;
        end
        cur_busy = 1'b0;
      end
      if (!cur_busy && rq_count > 0) begin
        cur_id = ready_q[rq_head];
        rq_head++;
        rq_count--;
        cur_busy = 1'b1;
        slice_used = '0;
      end
      if (cur_busy) begin
        t = cur_id;
        r.run_v = 1'b1;
        r.run_t = t;
        ticks_done[t]++;
        if (slice_used != SLICE_MAX) slice_used++;
        if (ticks_done[t] >= burst_need[t]) begin
          r.done_v = 1'b1;
          r.done_t = t;
          r.tat = sim_time + TIME_W'(1) - arrived_at[t];
          r.wt = r.tat - burst_need[t];
          is_active[t] = 1'b0;
          cur_busy = 1'b0;
          slice_used = '0;
        end
      end
      sim_time++;
    end
    return r;
  endfunction

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  // result checking and request capture
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        got_result = '{status_e'(status_o), running_valid_o, running_task_o, done_valid_o,
                       done_task_o, turnaround_o, waiting_o, time_now_o};
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request pending, expected none, actual %h",
                   $time, got_result);
        end else begin
          model_result = pending_results.pop_front();
          check_field("status", model_result.status, got_result.status);
          check_field("running_valid", model_result.run_v, got_result.run_v);
          check_field("running_task", model_result.run_t, got_result.run_t);
          check_field("done_valid", model_result.done_v, got_result.done_v);
          check_field("done_task", model_result.done_t, got_result.done_t);
          check_field("turnaround", model_result.tat, got_result.tat);
          check_field("waiting", model_result.wt, got_result.wt);
          check_field("time_now", model_result.now, got_result.now);
        end
      end
      if (start && !busy) begin
        model_result = next_sched_result(action_e'(action_i), task_id_i, burst_len_i);
        pending_results.push_back(typed_valid ? typed_result : model_result);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired with %0d results pending", $time,
                 pending_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_request(action_e act, logic [ID_W-1:0] id, logic [BURST_W-1:0] burst,
                              bit checked, sched_result_t want);
    while (gaps_on && $urandom_range(0, 99) < 50) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    action_i    <= act;
    task_id_i   <= id;
    burst_len_i <= burst;
    typed_valid  <= checked;
    typed_result <= want;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic send_random(int unsigned long_max);
    logic [BURST_W-1:0] b;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) b = '0;
    else if (pick < 85) b = BURST_W'($urandom_range(1, 12));
    else b = BURST_W'($urandom_range(13, long_max));
    if ($urandom_range(0, 99) < 60)
      send_request(ACT_TICK, ID_W'($urandom_range(0, MAX_TASKS - 1)), b, 1'b0, '0);
    else
      send_request(ACT_ARRIVE, ID_W'($urandom_range(0, MAX_TASKS - 1)), b, 1'b0, '0);
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic set_quantum(logic [QUANT_W-1:0] q);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= q;
    quantum_cfg = q;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(logic [QUANT_W-1:0] q, int n, int unsigned long_max);
    set_quantum(q);
    repeat (n) send_random(long_max);
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    action_i     = ACT_ARRIVE;
    task_id_i    = '0;
    burst_len_i  = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    typed_valid  = 1'b0;
    typed_result = '0;
    gaps_on      = 1'b1;
    foreach (is_active[i]) is_active[i] = 1'b0;
    dir_rows = '{
      '{ACT_TICK,   4'd0,  16'd0,     1'b1, '{ST_OK, 1'b0, 4'd0, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0}},
      '{ACT_ARRIVE, 4'd0,  16'd1,     1'b1, '{ST_OK, 1'b0, 4'd0, 1'b0, 4'd0, 16'd0, 16'd0, 16'd1}},
      '{ACT_ARRIVE, 4'd0,  16'd5,     1'b1, '{ST_BUSY, 1'b0, 4'd0, 1'b0, 4'd0, 16'd0, 16'd0, 16'd1}},
      '{ACT_ARRIVE, 4'd15, 16'hFFFF,  1'b1, '{ST_OK, 1'b0, 4'd0, 1'b0, 4'd0, 16'd0, 16'd0, 16'd1}},
      '{ACT_TICK,   4'd0,  16'd0,     1'b0, '0},
      '{ACT_ARRIVE, 4'd1,  16'd0,     1'b0, '0},
      '{ACT_ARRIVE, 4'd2,  16'd1,     1'b0, '0},
      '{ACT_ARRIVE, 4'd3,  16'd2,     1'b0, '0},
      '{ACT_ARRIVE, 4'd4,  16'd3,     1'b0, '0},
      '{ACT_ARRIVE, 4'd5,  16'd4,     1'b0, '0},
      '{ACT_ARRIVE, 4'd6,  16'd2,     1'b0, '0},
      '{ACT_ARRIVE, 4'd7,  16'd1,     1'b0, '0},
      '{ACT_ARRIVE, 4'd8,  16'd0,     1'b0, '0},
      '{ACT_ARRIVE, 4'd9,  16'd3,     1'b0, '0},
      '{ACT_ARRIVE, 4'd10, 16'd2,     1'b0, '0},
      '{ACT_ARRIVE, 4'd11, 16'd5,     1'b0, '0},
      '{ACT_ARRIVE, 4'd12, 16'd1,     1'b0, '0},
      '{ACT_ARRIVE, 4'd13, 16'd2,     1'b0, '0},
      '{ACT_ARRIVE, 4'd14, 16'd4,     1'b0, '0},
      '{ACT_ARRIVE, 4'd0,  16'd3,     1'b0, '0},
      '{ACT_ARRIVE, 4'd7,  16'd9,     1'b1, '{ST_FULL, 1'b0, 4'd0, 1'b0, 4'd0, 16'd0, 16'd0, 16'd2}},
      '{ACT_TICK,   4'd0,  16'd0,     1'b0, '0},
      '{ACT_TICK,   4'd0,  16'd0,     1'b0, '0},
      '{ACT_TICK,   4'd0,  16'd0,     1'b0, '0}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_request(dir_rows[i].act, dir_rows[i].id, dir_rows[i].burst, dir_rows[i].checked,
                   dir_rows[i].want);

    run_phase(QUANT_W'(1), 110, 40);
    run_phase(QUANT_W'(0), 110, 40);
    run_phase(QUANT_W'(255), 110, 600);
    run_phase(QUANT_W'($urandom_range(3, 254)), 110, 200);
    run_phase(QUANT_W'(3), 110, 40);

    // back-to-back requests with no gaps
    set_quantum(QUANT_W'(8));
    gaps_on = 1'b0;
    repeat (100) send_random(40);
    gaps_on = 1'b1;

    drain();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rrts_pkg.sv
rtl/rrts_ctrl.sv
rtl/rrts_dp.sv
rtl/round_robin_time_slice_scheduler.sv
sim/tb.sv
